@@ hdl/assert_macros.svh @@
// Assertion macros shared by the calibrator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define OTC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// check that a condition never holds outside reset
`define OTC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

@@ hdl/otc_pkg.sv @@
// Package with widths, codes and control types of the oscillator trim calibrator
`timescale 1ns / 1ps
package otc_pkg;

    localparam int TS_W      = 32;
    localparam int SUM_W     = 37;
    localparam int ERR_W     = 33;
    localparam int ERR_STEPS = 34;
    localparam int CNT_W     = 6;
    localparam int TRIM_W    = 6;
    localparam int TOL_W     = 16;
    localparam int EDGE_W    = 8;
    localparam int SETTLE_W  = 4;
    localparam int AVG_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam logic [TS_W-1:0]     TARGET_RST   = 32'd32000000;
    localparam logic [TOL_W-1:0]    TOL_RST      = 16'd16;
    localparam logic [EDGE_W-1:0]   START_RST    = 8'd5;
    localparam logic [SETTLE_W-1:0] SETTLE_RST   = 4'd2;
    localparam logic [AVG_W-1:0]    AVG_RST      = 5'd5;
    localparam logic [TRIM_W-1:0]   INIT_TRIM_RST = 6'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET,
        CFG_TOL,
        CFG_START,
        CFG_SETTLE,
        CFG_AVG,
        CFG_INIT_TRIM
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_DIV,
        S_ELD,
        S_ERR,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic ts_phase;
        logic acc_en;
        logic pvalid;
        logic div_step;
    } t_acc_ctl;

    typedef struct packed {
        logic clear;
        logic step;
    } t_div_ctl;

    typedef struct packed {
        logic load;
        logic step;
    } t_err_ctl;

endpackage

@@ hdl/otc_accum.sv @@
// Bit-serial period subtractor and window accumulator
`timescale 1ns / 1ps
module otc_accum (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  otc_pkg::t_acc_ctl             i_ctl,
    input  logic [otc_pkg::TS_W-1:0]      i_ts,
    output logic                          o_sum_msb,
    output logic [otc_pkg::TS_W-1:0]      o_period
);
    import otc_pkg::*;

    logic [TS_W-1:0]  r_prev;
    logic [TS_W-1:0]  r_ts_sh;
    logic [TS_W-1:0]  r_period;
    logic [SUM_W-1:0] r_sum;
    logic             r_br;
    logic             r_cy;

    logic a_bit;
    logic b_bit;
    logic d_bit;
    logic n_br;
    logic p_bit;
    logic add_bit;
    logic s_bit;
    logic n_cy;

    always_comb begin
        a_bit   = r_ts_sh[0];
        b_bit   = r_prev[0];
        d_bit   = a_bit ^ b_bit ^ r_br;
        n_br    = (~a_bit & b_bit) | (~(a_bit ^ b_bit) & r_br);
        p_bit   = i_ctl.pvalid & d_bit;
        add_bit = i_ctl.acc_en & i_ctl.ts_phase & p_bit;
        s_bit   = r_sum[0] ^ add_bit ^ r_cy;
        n_cy    = (r_sum[0] & add_bit) | (r_cy & (r_sum[0] ^ add_bit));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_sum  <= '0;
        end else if (i_ctl.step) begin
            r_sum <= {s_bit, r_sum[SUM_W-1:1]};
            if (i_ctl.ts_phase) begin
                r_prev <= {a_bit, r_prev[TS_W-1:1]};
            end
        end else if (i_ctl.div_step) begin
            r_sum <= {r_sum[SUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ts_sh <= i_ts;
            r_br    <= 1'b0;
            r_cy    <= 1'b0;
        end else if (i_ctl.step) begin
            r_cy <= n_cy;
            if (i_ctl.ts_phase) begin
                r_ts_sh  <= {1'b0, r_ts_sh[TS_W-1:1]};
                r_br     <= n_br;
                r_period <= {p_bit, r_period[TS_W-1:1]};
            end
        end
    end

    assign o_sum_msb = r_sum[SUM_W-1];
    assign o_period  = r_period;

endmodule

@@ hdl/otc_div.sv @@
// Bit-serial restoring divider for the window average
`timescale 1ns / 1ps
module otc_div (
    input  logic                      i_clk,
    input  otc_pkg::t_div_ctl         i_ctl,
    input  logic                      i_bit,
    input  logic [otc_pkg::AVG_W-1:0] i_n,
    output logic [otc_pkg::TS_W-1:0]  o_quot
);
    import otc_pkg::*;

    logic [AVG_W-1:0] r_rem;
    logic [TS_W-1:0]  r_quot;

    logic [AVG_W:0]   trial;
    logic             ge;
    logic [AVG_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, i_bit};
        ge    = trial >= {1'b0, i_n};
        n_rem = ge ? AVG_W'(trial - {1'b0, i_n}) : trial[AVG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_rem <= '0;
        end else if (i_ctl.step) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[TS_W-2:0], ge};
        end
    end

    assign o_quot = r_quot;

endmodule

@@ hdl/otc_err.sv @@
// Bit-serial error subtractor and tolerance comparator
`timescale 1ns / 1ps
module otc_err (
    input  logic                       i_clk,
    input  otc_pkg::t_err_ctl          i_ctl,
    input  logic [otc_pkg::TS_W-1:0]   i_avg,
    input  logic [otc_pkg::TS_W-1:0]   i_target,
    input  logic [otc_pkg::TOL_W-1:0]  i_tol,
    output logic [otc_pkg::ERR_W-1:0]  o_err,
    output logic                       o_neg,
    output logic                       o_within
);
    import otc_pkg::*;

    logic [TS_W-1:0]      r_a;
    logic [TS_W-1:0]      r_t;
    logic [TOL_W-1:0]     r_tol;
    logic [ERR_STEPS-1:0] r_e;
    logic                 r_b1;
    logic                 r_b2;
    logic                 r_c;
    logic                 r_d_sign;
    logic                 r_s_sign;

    logic a_bit;
    logic t_bit;
    logic l_bit;
    logic e_bit;
    logic d_bit;
    logic s_bit;
    logic n_b1;
    logic n_b2;
    logic n_c;

    always_comb begin
        a_bit = r_a[0];
        t_bit = r_t[0];
        l_bit = r_tol[0];
        e_bit = a_bit ^ t_bit ^ r_b1;
        n_b1  = (~a_bit & t_bit) | (~(a_bit ^ t_bit) & r_b1);
        d_bit = l_bit ^ e_bit ^ r_b2;
        n_b2  = (~l_bit & e_bit) | (~(l_bit ^ e_bit) & r_b2);
        s_bit = l_bit ^ e_bit ^ r_c;
        n_c   = (l_bit & e_bit) | (r_c & (l_bit ^ e_bit));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a   <= i_avg;
            r_t   <= i_target;
            r_tol <= i_tol;
            r_b1  <= 1'b0;
            r_b2  <= 1'b0;
            r_c   <= 1'b0;
        end else if (i_ctl.step) begin
            r_a      <= {1'b0, r_a[TS_W-1:1]};
            r_t      <= {1'b0, r_t[TS_W-1:1]};
            r_tol    <= {1'b0, r_tol[TOL_W-1:1]};
            r_b1     <= n_b1;
            r_b2     <= n_b2;
            r_c      <= n_c;
            r_e      <= {e_bit, r_e[ERR_STEPS-1:1]};
            r_d_sign <= d_bit;
            r_s_sign <= s_bit;
        end
    end

    assign o_err    = r_e[ERR_W-1:0];
    assign o_neg    = r_e[ERR_STEPS-1];
    assign o_within = r_e[ERR_STEPS-1] ? ~r_s_sign : ~r_d_sign;

endmodule

@@ hdl/oscillator_trim_calibrator.sv @@
// Oscillator trim calibrator top level: control sequencer, state and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"
// One transaction per reference edge. An edge that does not close an averaging window
// takes a serial pass through the period subtractor and window accumulator, plus load
// and hold, from acceptance to result; an edge that closes a window adds a pass of
// the one-bit-per-cycle divider, an error load and a serial error and tolerance
// pass. The next transaction is accepted once the sequencer is back in idle, while a
// finished result may still wait on the output.
module oscillator_trim_calibrator #(
    parameter int TRIM_MAX    = 63,
    parameter int MAX_AVERAGE = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [otc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [otc_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [otc_pkg::TS_W-1:0]         i_edge_timestamp,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [otc_pkg::TS_W-1:0]         o_period_cycles,
    output logic                             o_period_valid,
    output logic                             o_average_ready,
    output logic [otc_pkg::TS_W-1:0]         o_average_cycles,
    output logic signed [otc_pkg::ERR_W-1:0] o_error_cycles,
    output logic [otc_pkg::TRIM_W-1:0]       o_trim_code,
    output logic                             o_trim_changed,
    output logic                             o_converged,
    output logic [otc_pkg::EDGE_W-1:0]       o_adjustments
);
    import otc_pkg::*;

    localparam int AVG_TOP  = (1 << AVG_W) - 1;
    localparam int TRIM_TOP = (1 << TRIM_W) - 1;
    localparam logic [AVG_W-1:0]  AVG_CAP  =
        AVG_W'((MAX_AVERAGE > AVG_TOP) ? AVG_TOP : MAX_AVERAGE);
    localparam logic [TRIM_W-1:0] TRIM_LIM =
        TRIM_W'((TRIM_MAX > TRIM_TOP) ? TRIM_TOP : TRIM_MAX);
    localparam logic [CNT_W-1:0]  SUM_LAST = CNT_W'(SUM_W - 1);
    localparam logic [CNT_W-1:0]  ERR_LAST = CNT_W'(ERR_STEPS - 1);
    localparam logic [CNT_W-1:0]  TS_STEPS = CNT_W'(TS_W);

    // configuration
    logic [TS_W-1:0]     r_cfg_target;
    logic [TOL_W-1:0]    r_cfg_tol;
    logic [EDGE_W-1:0]   r_cfg_start;
    logic [SETTLE_W-1:0] r_cfg_settle;
    logic [AVG_W-1:0]    r_cfg_avg;
    logic [TRIM_W-1:0]   r_cfg_init_trim;

    // calibration state
    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    n_cnt;
    logic                r_have_prev;
    logic [EDGE_W-1:0]   r_edge_cnt;
    logic                r_loaded;
    logic [TRIM_W-1:0]   r_trim;
    logic [SETTLE_W-1:0] r_settle;
    logic [AVG_W-1:0]    r_wcnt;
    logic [TS_W-1:0]     r_last_avg;
    logic [ERR_W-1:0]    r_last_err;
    logic                r_conv;
    logic [EDGE_W-1:0]   r_steps;

    // per-transaction flags
    logic                r_pvalid;
    logic                r_acc;
    logic                r_do_div;

    // result register
    logic                r_out_valid;
    logic [TS_W-1:0]     r_out_period;
    logic                r_out_pvalid;
    logic                r_out_avg_rdy;
    logic [TRIM_W-1:0]   r_out_trim;
    logic                r_out_changed;

    t_acc_ctl            acc_ctl;
    t_div_ctl            div_ctl;
    t_err_ctl            err_ctl;
    logic                sum_msb;
    logic [TS_W-1:0]     period;
    logic [TS_W-1:0]     quot;
    logic [ERR_W-1:0]    err;
    logic                err_neg;
    logic                err_within;

    logic                accept;
    logic                commit;
    logic [EDGE_W-1:0]   ecnt_n;
    logic                cal;
    logic [TRIM_W-1:0]   trim_v;
    logic [SETTLE_W-1:0] settle_v;
    logic [AVG_W-1:0]    n_eff;
    logic [AVG_W-1:0]    wcnt_n;
    logic                acc_now;
    logic                div_now;
    logic [TRIM_W-1:0]   trim_c;
    logic                conv_c;
    logic                changed_c;

    assign accept = i_in_valid && o_in_ready;
    assign commit = (r_state == S_HOLD) && (!r_out_valid || i_out_ready);

    // acceptance decisions
    always_comb begin
        ecnt_n   = (r_edge_cnt == '1) ? r_edge_cnt : r_edge_cnt + EDGE_W'(1);
        cal      = ecnt_n >= r_cfg_start;
        trim_v   = r_loaded ? r_trim : r_cfg_init_trim;
        settle_v = r_loaded ? r_settle : r_cfg_settle;
        if (r_cfg_avg == '0) begin
            n_eff = AVG_W'(1);
        end else if (r_cfg_avg > AVG_CAP) begin
            n_eff = AVG_CAP;
        end else begin
            n_eff = r_cfg_avg;
        end
        wcnt_n  = r_wcnt + AVG_W'(1);
        acc_now = cal && (settle_v == '0);
        div_now = acc_now && (wcnt_n >= n_eff);
    end

    // trim decision at the end of a window
    always_comb begin
        trim_c    = r_trim;
        conv_c    = r_conv;
        changed_c = 1'b0;
        if (r_do_div) begin
            conv_c = 1'b1;
            if (!err_within) begin
                if (!err_neg) begin
                    if (r_trim < TRIM_LIM) begin
                        trim_c    = r_trim + TRIM_W'(1);
                        changed_c = 1'b1;
                        conv_c    = 1'b0;
                    end
                end else if (r_trim != '0) begin
                    trim_c    = r_trim - TRIM_W'(1);
                    changed_c = 1'b1;
                    conv_c    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_target    <= TARGET_RST;
            r_cfg_tol       <= TOL_RST;
            r_cfg_start     <= START_RST;
            r_cfg_settle    <= SETTLE_RST;
            r_cfg_avg       <= AVG_RST;
            r_cfg_init_trim <= INIT_TRIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET:    r_cfg_target    <= i_cfg_data;
                CFG_TOL:       r_cfg_tol       <= i_cfg_data[TOL_W-1:0];
                CFG_START:     r_cfg_start     <= i_cfg_data[EDGE_W-1:0];
                CFG_SETTLE:    r_cfg_settle    <= i_cfg_data[SETTLE_W-1:0];
                CFG_AVG:       r_cfg_avg       <= i_cfg_data[AVG_W-1:0];
                CFG_INIT_TRIM: r_cfg_init_trim <= i_cfg_data[TRIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_cnt            = r_cnt + CNT_W'(1);
        acc_ctl          = '0;
        acc_ctl.ts_phase = r_cnt < TS_STEPS;
        acc_ctl.acc_en   = r_acc;
        acc_ctl.pvalid   = r_pvalid;
        div_ctl          = '0;
        err_ctl          = '0;
        o_in_ready       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                n_cnt      = '0;
                if (i_in_valid) begin
                    acc_ctl.load  = 1'b1;
                    div_ctl.clear = 1'b1;
                    n_state       = S_ADD;
                end
            end
            S_ADD: begin
                acc_ctl.step = 1'b1;
                if (r_cnt == SUM_LAST) begin
                    n_cnt   = '0;
                    n_state = r_do_div ? S_DIV : S_HOLD;
                end
            end
            S_DIV: begin
                div_ctl.step     = 1'b1;
                acc_ctl.div_step = 1'b1;
                if (r_cnt == SUM_LAST) begin
                    n_cnt   = '0;
                    n_state = S_ELD;
                end
            end
            S_ELD: begin
                err_ctl.load = 1'b1;
                n_cnt        = '0;
                n_state      = S_ERR;
            end
            S_ERR: begin
                err_ctl.step = 1'b1;
                if (r_cnt == ERR_LAST) begin
                    n_cnt   = '0;
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                n_cnt = '0;
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_cnt   = '0;
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_edge_cnt  <= '0;
            r_loaded    <= 1'b0;
            r_trim      <= '0;
            r_settle    <= SETTLE_RST;
            r_wcnt      <= '0;
            r_last_avg  <= '0;
            r_last_err  <= '0;
            r_conv      <= 1'b0;
            r_steps     <= '0;
            r_pvalid    <= 1'b0;
            r_acc       <= 1'b0;
            r_do_div    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_have_prev <= 1'b1;
                r_pvalid    <= r_have_prev;
                r_edge_cnt  <= ecnt_n;
                r_acc       <= acc_now;
                r_do_div    <= div_now;
                if (cal) begin
                    r_loaded <= 1'b1;
                    r_trim   <= trim_v;
                    if (settle_v != '0) begin
                        r_settle <= settle_v - SETTLE_W'(1);
                    end else begin
                        r_settle <= settle_v;
                        r_wcnt   <= div_now ? '0 : wcnt_n;
                    end
                end
            end
            if (commit) begin
                r_out_valid <= 1'b1;
                r_trim      <= trim_c;
                r_conv      <= conv_c;
                if (r_do_div) begin
                    r_last_avg <= quot;
                    r_last_err <= err;
                end
                if (changed_c) begin
                    r_steps  <= r_steps + EDGE_W'(1);
                    r_settle <= r_cfg_settle;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_period  <= period;
            r_out_pvalid  <= r_pvalid;
            r_out_avg_rdy <= r_do_div;
            r_out_trim    <= r_loaded ? trim_c : r_cfg_init_trim;
            r_out_changed <= changed_c;
        end
    end

    otc_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (acc_ctl),
        .i_ts      (i_edge_timestamp),
        .o_sum_msb (sum_msb),
        .o_period  (period)
    );

    otc_div u_div (
        .i_clk  (i_clk),
        .i_ctl  (div_ctl),
        .i_bit  (sum_msb),
        .i_n    (n_eff),
        .o_quot (quot)
    );

    otc_err u_err (
        .i_clk    (i_clk),
        .i_ctl    (err_ctl),
        .i_avg    (quot),
        .i_target (r_cfg_target),
        .i_tol    (r_cfg_tol),
        .o_err    (err),
        .o_neg    (err_neg),
        .o_within (err_within)
    );

    assign o_out_valid      = r_out_valid;
    assign o_period_cycles  = r_out_period;
    assign o_period_valid   = r_out_pvalid;
    assign o_average_ready  = r_out_avg_rdy;
    assign o_average_cycles = r_last_avg;
    assign o_error_cycles   = r_last_err;
    assign o_trim_code      = r_out_trim;
    assign o_trim_changed   = r_out_changed;
    assign o_converged      = r_conv;
    assign o_adjustments    = r_steps;

    `OTC_ASSERT(a_accept_starts_pass, accept |=> (r_state == S_ADD), "accept did not start a pass")
    `OTC_ASSERT(a_valid_from_hold, $rose(o_out_valid) |-> ($past(r_state) == S_HOLD), "result raised outside hold")
    `OTC_ASSERT(a_change_needs_window, (o_out_valid && o_trim_changed) |-> o_average_ready, "trim stepped without a finished window")
    `OTC_ASSERT_NEVER(a_window_count_range, r_wcnt >= AVG_CAP, "window count past its limit")

endmodule
